[hdl/jis2sjis_pkg.sv]
// Package for the JIS to Shift_JIS encoder.
// Holds the beat types, character set codes and status codes; no dependencies.
`default_nettype none

package jis2sjis_pkg;

  localparam logic [2:0] CS_ROMAN    = 3'd0;
  localparam logic [2:0] CS_KATAKANA = 3'd1;
  localparam logic [2:0] CS_X0208    = 3'd2;
  localparam logic [2:0] CS_IBM_EXT  = 3'd3;
  localparam logic [2:0] CS_X0213_P1 = 3'd4;
  localparam logic [2:0] CS_X0213_P2 = 3'd5;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ILLEGAL     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [2:0] char_set;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [1:0] byte_count;
    logic [1:0] status;
  } out_beat_t;

endpackage

`default_nettype wire

[hdl/jis_to_shift_jis_encoder.sv]
// A beat accepted goes into the input register, then into the result register, which drives the output.
// One character per cycle unless the output stalls; ready follows the output side combinationally.
// The input register and the result register each hold one beat.
// Reset clears both stage valid flags and sets the mode to plain Shift_JIS.
// Depends on jis2sjis_pkg for the beat types and codes.
`default_nettype none

module jis_to_shift_jis_encoder (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire jis2sjis_pkg::in_beat_t  in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      jis2sjis_pkg::out_beat_t out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_wdata_i
);

  logic                    mode_q;
  logic                    in_vld_q;
  jis2sjis_pkg::in_beat_t  in_q;
  logic                    res_vld_q;
  jis2sjis_pkg::out_beat_t res_q;
  jis2sjis_pkg::out_beat_t res_d;

  logic res_adv;
  logic in_adv;

  logic [7:0] b1;
  logic [7:0] b2;
  logic [8:0] row_diff;
  logic [8:0] row_adj;
  logic [8:0] row_half;
  logic [8:0] cls_hi9;
  logic [8:0] cls_lo9;
  logic [7:0] cls_hi;
  logic [7:0] cls_lo;
  logic [7:0] x13_cell;
  logic [8:0] p1_sum;
  logic [8:0] p2l_sum;
  logic [8:0] p2r_sum;
  logic [7:0] p2l_hi;
  logic       p2_listed;
  logic       p2_range;

  assign res_adv    = !res_vld_q || out_ready_i;
  assign in_adv     = !in_vld_q || res_adv;
  assign in_ready_o = in_adv;

  assign b1 = in_q.first_byte;
  assign b2 = in_q.second_byte;

  // Classic row arithmetic; the halving truncates toward zero for rows below 0x21.
  always_comb begin
    row_diff = {1'b0, b1} - 9'd33;
    row_adj  = row_diff + {8'd0, row_diff[8]};
    row_half = {row_adj[8], row_adj[8:1]};
    cls_hi9  = row_half + 9'h081;
    if (cls_hi9 > 9'h09f) begin
      cls_hi9 = cls_hi9 + 9'h040;
    end
    cls_lo9 = {1'b0, b2} + (b1[0] ? 9'h01f : 9'h07d);
    if (cls_lo9 >= 9'h07f) begin
      cls_lo9 = cls_lo9 + 9'd1;
    end
    cls_hi = cls_hi9[7:0];
    cls_lo = cls_lo9[7:0];
  end

  always_comb begin
    if (b1[0]) begin
      if (b2 <= 8'h5f) begin
        x13_cell = b2 + 8'h1f;
      end else if (b2 <= 8'h7e) begin
        x13_cell = b2 + 8'h20;
      end else begin
        x13_cell = b2;
      end
    end else begin
      x13_cell = b2 + 8'h7e;
    end
    p1_sum    = {1'b0, b1} + ((b1 <= 8'h5e) ? 9'h0e1 : 9'h161);
    p2l_sum   = {1'b0, b1} + 9'h1bf;
    p2r_sum   = {1'b0, b1} + 9'h17b;
    p2l_hi    = p2l_sum[8:1] - ((b1 >= 8'h28) ? 8'd3 : 8'd0);
    p2_listed = b1 inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h28, 8'h2c, 8'h2d, 8'h2e, 8'h2f};
    p2_range  = b1 inside {[8'h6e : 8'h7e]};
  end

  always_comb begin
    res_d = '{out_first: 8'd0, out_second: 8'd0,
              byte_count: jis2sjis_pkg::CNT_NONE, status: jis2sjis_pkg::ST_UNSUPPORTED};
    case (in_q.char_set)
      jis2sjis_pkg::CS_ROMAN: begin
        res_d.out_first  = b1;
        res_d.byte_count = jis2sjis_pkg::CNT_ONE;
        res_d.status     = jis2sjis_pkg::ST_OK;
      end
      jis2sjis_pkg::CS_KATAKANA: begin
        res_d.out_first  = b1 | 8'h80;
        res_d.byte_count = jis2sjis_pkg::CNT_ONE;
        res_d.status     = jis2sjis_pkg::ST_OK;
      end
      jis2sjis_pkg::CS_X0208: begin
        if (!mode_q) begin
          res_d.out_first  = cls_hi;
          res_d.out_second = cls_lo;
          res_d.byte_count = jis2sjis_pkg::CNT_TWO;
          res_d.status     = jis2sjis_pkg::ST_OK;
        end
      end
      jis2sjis_pkg::CS_IBM_EXT: begin
        if (!mode_q) begin
          res_d.out_first  = b1;
          res_d.out_second = b2;
          res_d.byte_count = jis2sjis_pkg::CNT_TWO;
          res_d.status     = jis2sjis_pkg::ST_OK;
        end
      end
      jis2sjis_pkg::CS_X0213_P1: begin
        if (mode_q) begin
          if (b1 <= 8'h7e) begin
            res_d.out_first  = p1_sum[8:1];
            res_d.out_second = x13_cell;
            res_d.byte_count = jis2sjis_pkg::CNT_TWO;
            res_d.status     = jis2sjis_pkg::ST_OK;
          end else begin
            res_d.status = jis2sjis_pkg::ST_ILLEGAL;
          end
        end
      end
      jis2sjis_pkg::CS_X0213_P2: begin
        if (mode_q) begin
          if (p2_listed || p2_range) begin
            res_d.out_first  = p2_listed ? p2l_hi : p2r_sum[8:1];
            res_d.out_second = x13_cell;
            res_d.byte_count = jis2sjis_pkg::CNT_TWO;
            res_d.status     = jis2sjis_pkg::ST_OK;
          end else begin
            res_d.status = jis2sjis_pkg::ST_ILLEGAL;
          end
        end
      end
      default: begin
        res_d.status = jis2sjis_pkg::ST_UNSUPPORTED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (in_adv) begin
        in_vld_q <= in_valid_i;
      end
      if (res_adv) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (res_adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  a_fail_no_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != jis2sjis_pkg::ST_OK)
      |-> (out_data_o.byte_count == jis2sjis_pkg::CNT_NONE))
    else $error("A failed character carries bytes.");

  a_second_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.byte_count != jis2sjis_pkg::CNT_TWO)
      |-> (out_data_o.out_second == 8'd0))
    else $error("Unused second byte is not zero.");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input stalled while the result register is empty.");

  a_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && res_adv |=> out_valid_o)
    else $error("A registered beat did not reach the result register.");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the JIS to Shift_JIS encoder.
// Predicts every result beat from the character and the mode, then checks each output beat in order.
// Depends on jis2sjis_pkg and jis_to_shift_jis_encoder.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CS_OTHER    = 3'd6;
  localparam logic [2:0] CS_RESERVED = 3'd7;
  localparam logic       MODE_PLAIN  = 1'b0;
  localparam logic       MODE_X0213  = 1'b1;
  localparam int PIPE_LATENCY   = 2;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int CHARS_PER_PHASE = 48;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  jis2sjis_pkg::in_beat_t  in_data_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  jis2sjis_pkg::out_beat_t out_data_o;
  logic                    cfg_we_i    = 1'b0;
  logic                    cfg_wdata_i = 1'b0;

  jis2sjis_pkg::out_beat_t expected_sjis[$];
  logic      mode_q = MODE_PLAIN;
  int        err_cnt = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      holding = 1'b0;
  event      holdoff_ev;

  jis_to_shift_jis_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic int x0213_cell_byte(int row, int col);
    if (row % 2 == 1) begin
      if (col <= 'sh5f) return col + 'sh1f;
      if (col <= 'sh7e) return col + 'sh20;
      return col;
    end
    return col + 'sh7e;
  endfunction

  function automatic jis2sjis_pkg::out_beat_t sjis_encode(jis2sjis_pkg::in_beat_t c,
                                                         logic x0213);
    jis2sjis_pkg::out_beat_t r;
    int row;
    int col;
    int hi;
    int lo;
    logic listed;
    r = '0;
    row = int'(c.first_byte);
    col = int'(c.second_byte);
    hi = 0;
    lo = 0;
    r.status = jis2sjis_pkg::ST_OK;
    r.byte_count = jis2sjis_pkg::CNT_NONE;
    case (c.char_set)
      jis2sjis_pkg::CS_ROMAN: begin
        hi = row;
        r.byte_count = jis2sjis_pkg::CNT_ONE;
      end
      jis2sjis_pkg::CS_KATAKANA: begin
        hi = row | 'sh80;
        r.byte_count = jis2sjis_pkg::CNT_ONE;
      end
      jis2sjis_pkg::CS_X0208: begin
        if (x0213) begin
          r.status = jis2sjis_pkg::ST_UNSUPPORTED;
        end else begin
          lo = col + ((row % 2 == 1) ? 'sh1f : 'sh7d);
          if (lo >= 'sh7f) lo = lo + 1;
          hi = (row - 'sh21) / 2 + 'sh81;
          if (hi > 'sh9f) hi = hi + 'sh40;
          r.byte_count = jis2sjis_pkg::CNT_TWO;
        end
      end
      jis2sjis_pkg::CS_IBM_EXT: begin
        if (x0213) begin
          r.status = jis2sjis_pkg::ST_UNSUPPORTED;
        end else begin
          hi = row;
          lo = col;
          r.byte_count = jis2sjis_pkg::CNT_TWO;
        end
      end
      jis2sjis_pkg::CS_X0213_P1: begin
        if (!x0213) begin
          r.status = jis2sjis_pkg::ST_UNSUPPORTED;
        end else if (row <= 'sh7e) begin
          hi = (row <= 'sh5e) ? (row + 'she1) / 2 : (row + 'sh161) / 2;
          lo = x0213_cell_byte(row, col);
          r.byte_count = jis2sjis_pkg::CNT_TWO;
        end else begin
          r.status = jis2sjis_pkg::ST_ILLEGAL;
        end
      end
      jis2sjis_pkg::CS_X0213_P2: begin
        case (row)
          'sh21, 'sh23, 'sh24, 'sh25, 'sh28, 'sh2c, 'sh2d, 'sh2e, 'sh2f: listed = 1'b1;
          default: listed = 1'b0;
        endcase
        if (!x0213) begin
          r.status = jis2sjis_pkg::ST_UNSUPPORTED;
        end else if (listed) begin
          hi = (row + 'sh1bf) / 2 - ((row - 'sh20) / 8) * 3;
          lo = x0213_cell_byte(row, col);
          r.byte_count = jis2sjis_pkg::CNT_TWO;
        end else if (row >= 'sh6e && row <= 'sh7e) begin
          hi = (row + 'sh17b) / 2;
          lo = x0213_cell_byte(row, col);
          r.byte_count = jis2sjis_pkg::CNT_TWO;
        end else begin
          r.status = jis2sjis_pkg::ST_ILLEGAL;
        end
      end
      default: r.status = jis2sjis_pkg::ST_UNSUPPORTED;
    endcase
    r.out_first  = (r.byte_count >= jis2sjis_pkg::CNT_ONE) ? hi[7:0] : 8'h00;
    r.out_second = (r.byte_count >= jis2sjis_pkg::CNT_TWO) ? lo[7:0] : 8'h00;
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range('h7e, 'h21));
  endfunction

  function automatic jis2sjis_pkg::in_beat_t random_char(logic x0213);
    jis2sjis_pkg::in_beat_t c;
    int pick;
    pick = $urandom_range(99);
    c.first_byte = random_byte();
    c.second_byte = random_byte();
    if (pick < 25) begin
      c.char_set = 3'($urandom_range(7));
    end else if (pick < 40) begin
      c.char_set = $urandom_range(1) ? jis2sjis_pkg::CS_ROMAN : jis2sjis_pkg::CS_KATAKANA;
    end else if (!x0213) begin
      c.char_set = $urandom_range(3) == 0 ? jis2sjis_pkg::CS_IBM_EXT : jis2sjis_pkg::CS_X0208;
    end else begin
      c.char_set = $urandom_range(1) ? jis2sjis_pkg::CS_X0213_P1 : jis2sjis_pkg::CS_X0213_P2;
    end
    if (x0213 && c.char_set == jis2sjis_pkg::CS_X0213_P2 && $urandom_range(1)) begin
      case ($urandom_range(9))
        0: c.first_byte = 8'h21;
        1: c.first_byte = 8'h23;
        2: c.first_byte = 8'h24;
        3: c.first_byte = 8'h25;
        4: c.first_byte = 8'h28;
        5: c.first_byte = 8'h2c;
        6: c.first_byte = 8'h2d;
        7: c.first_byte = 8'h2e;
        8: c.first_byte = 8'h2f;
        default: c.first_byte = 8'($urandom_range('h7e, 'h6e));
      endcase
    end
    return c;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_checker
    jis2sjis_pkg::out_beat_t want;
    logic moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        expected_sjis.push_back(sjis_encode(in_data_i, mode_q));
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_sjis.size() == 0) begin
          $error("Output beat 0x%0h arrived with no character pending", out_data_o);
          err_cnt++;
        end else begin
          want = expected_sjis.pop_front();
          check_field("out_first", int'(want.out_first), int'(out_data_o.out_first));
          check_field("out_second", int'(want.out_second), int'(out_data_o.out_second));
          check_field("byte_count", int'(want.byte_count), int'(out_data_o.byte_count));
          check_field("status", int'(want.status), int'(out_data_o.status));
        end
      end
      if (cfg_we_i) mode_q = cfg_wdata_i;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !holding && (int'($urandom_range(99)) >= recv_stall_pct);
  end

  always begin
    @(holdoff_ev);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  task automatic send_char(jis2sjis_pkg::in_beat_t c);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_sjis.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic set_mode(logic m);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_plain_directed();
    send_char({jis2sjis_pkg::CS_ROMAN, 8'h00, 8'h00});
    send_char({jis2sjis_pkg::CS_ROMAN, 8'hff, 8'hff});
    send_char({jis2sjis_pkg::CS_KATAKANA, 8'h00, 8'h55});
    send_char({jis2sjis_pkg::CS_KATAKANA, 8'h7f, 8'haa});
    send_char({jis2sjis_pkg::CS_X0208, 8'h21, 8'h21});
    send_char({jis2sjis_pkg::CS_X0208, 8'h5f, 8'h60});
    send_char({jis2sjis_pkg::CS_X0208, 8'h7e, 8'h7e});
    send_char({jis2sjis_pkg::CS_X0208, 8'h00, 8'hff});
    send_char({jis2sjis_pkg::CS_X0208, 8'hff, 8'h00});
    send_char({jis2sjis_pkg::CS_IBM_EXT, 8'hfa, 8'h40});
    send_char({jis2sjis_pkg::CS_X0213_P1, 8'h21, 8'h21});
    send_char({jis2sjis_pkg::CS_X0213_P2, 8'h21, 8'h21});
    send_char({CS_OTHER, 8'h41, 8'h42});
    send_char({CS_RESERVED, 8'hff, 8'hff});
  endtask

  task automatic test_x0213_directed();
    send_char({jis2sjis_pkg::CS_X0213_P1, 8'h21, 8'h21});
    send_char({jis2sjis_pkg::CS_X0213_P1, 8'h5e, 8'h7e});
    send_char({jis2sjis_pkg::CS_X0213_P1, 8'h5f, 8'h60});
    send_char({jis2sjis_pkg::CS_X0213_P1, 8'h7e, 8'hff});
    send_char({jis2sjis_pkg::CS_X0213_P1, 8'h7f, 8'h21});
    send_char({jis2sjis_pkg::CS_X0213_P1, 8'h00, 8'h00});
    send_char({jis2sjis_pkg::CS_X0213_P2, 8'h21, 8'h7f});
    send_char({jis2sjis_pkg::CS_X0213_P2, 8'h2f, 8'h5f});
    send_char({jis2sjis_pkg::CS_X0213_P2, 8'h6e, 8'h21});
    send_char({jis2sjis_pkg::CS_X0213_P2, 8'h7e, 8'h7e});
    send_char({jis2sjis_pkg::CS_X0213_P2, 8'h22, 8'h30});
    send_char({jis2sjis_pkg::CS_X0213_P2, 8'hff, 8'h30});
    send_char({jis2sjis_pkg::CS_X0208, 8'h30, 8'h30});
    send_char({jis2sjis_pkg::CS_IBM_EXT, 8'hfa, 8'h40});
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int m = 0; m < 2; m++) begin
        set_mode(m[0]);
        repeat (CHARS_PER_PHASE) send_char(random_char(mode_q));
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_mode(MODE_X0213);
    -> holdoff_ev;
    repeat (30) send_char(random_char(mode_q));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_directed();
    set_mode(MODE_X0213);
    test_x0213_directed();
    test_random_mix();
    test_backpressure();
    drain();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0 && expected_sjis.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
